>>> rtl/lfpd_pkg.sv
// Shared types, widths, constants and helpers for the line follower PD block.
// Used by lfpd_mac, the top level and the port checker.

package lfpd_pkg;

  // Field widths
  localparam int unsigned POS_W     = 12;
  localparam int unsigned SENS_W    = 10;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned WGT_W     = 13;
  localparam int unsigned SPD_W     = 9;
  localparam int unsigned THR_W     = 10;
  localparam int unsigned SPD_OUT_W = 10;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  // Datapath widths
  localparam int unsigned ERR_W   = 12;  // position error, signed
  localparam int unsigned DERR_W  = 13;  // error difference, signed
  localparam int unsigned PD_W    = 16;  // saturated PD term, signed
  localparam int unsigned STEER_W = 10;  // clamped steering term, signed
  localparam int unsigned SUM_W   = 11;  // base +/- steering, signed
  localparam int unsigned OPD_W   = 16;  // serial multiplier operand, signed
  localparam int unsigned MUL_W   = 16;  // serial multiplier digit source, unsigned
  localparam int unsigned ACC_W   = 32;  // product accumulator, signed
  localparam int unsigned FRAC_W  = 12;  // Q.12 fraction bits
  localparam int unsigned DIGIT_W = 4;   // bits of the multiplier per cycle

  // Constants
  localparam logic [POS_W-1:0] CENTRE_POS = 12'd2000;
  localparam logic [POS_W-1:0] MAX_POS    = 12'd4000;
  localparam logic [WGT_W-1:0] ONE_Q12    = 13'd4096;
  localparam logic [2:0]       MIN_ACTIVE = 3'd4;

  localparam logic signed [ACC_W-1:0] PD_MAX = 32'sd32767;
  localparam logic signed [ACC_W-1:0] PD_MIN = -32'sd32768;

  // Register reset values
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd527;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd322;
  localparam logic [WGT_W-1:0]  FILT_WGT_RST   = 13'd3277;
  localparam logic [SPD_W-1:0]  BASE_SPD_RST   = 9'd150;
  localparam logic [SPD_W-1:0]  STEER_LIM_RST  = 9'd220;
  localparam logic [SPD_W-1:0]  SPEED_LIM_RST  = 9'd300;
  localparam logic [THR_W-1:0]  CROSS_THR_RST  = 10'd600;
  localparam logic [THR_W-1:0]  CENTER_THR_RST = 10'd650;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_DERIV_GAIN = 3'd1,
    REG_FILT_WGT   = 3'd2,
    REG_BASE_SPD   = 3'd3,
    REG_STEER_LIM  = 3'd4,
    REG_SPEED_LIM  = 3'd5,
    REG_CROSS_THR  = 3'd6,
    REG_CENTER_THR = 3'd7
  } cfg_idx_e;

  // Request into the serial multiply-accumulate unit
  typedef struct packed {
    logic                    load;
    logic signed [OPD_W-1:0] opd_a;
    logic signed [OPD_W-1:0] opd_b;
    logic [MUL_W-1:0]        mul_a;
    logic [MUL_W-1:0]        mul_b;
  } mac_req_t;

  // Status from the serial multiply-accumulate unit
  typedef struct packed {
    logic                    busy;
    logic signed [ACC_W-1:0] acc;
  } mac_sts_t;

  // Divide by 4096 truncating toward zero
  function automatic logic signed [ACC_W-1:0] q12_trunc(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] bias;
    bias = v[ACC_W-1] ? $signed(ACC_W'((1 << FRAC_W) - 1)) : '0;
    return (v + bias) >>> FRAC_W;
  endfunction

endpackage

>>> rtl/line_follow_pd_with_crossing_detect.sv
// Line follower steering: PD term, low-pass filter, wheel clamps, crossing detect.
// Depends on lfpd_pkg and lfpd_mac.
// A request passes through S_PD_START, S_PD_WAIT, S_FI_START, S_FI_WAIT and S_OUT to the output register.
// Requests are taken one at a time: the input stalls until the previous one leaves S_OUT, set by the
// two passes through the shared digit-serial multiply-accumulate unit and held while the output stalls.
// Reset: async active low; registers to defaults, filter and crossing state to zero.

module line_follow_pd_with_crossing_detect #(
  parameter int unsigned DigitW = lfpd_pkg::DIGIT_W
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [lfpd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [lfpd_pkg::CFG_DAT_W-1:0]       cfg_data_i,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [lfpd_pkg::POS_W-1:0]           line_position_i,
  input  logic [lfpd_pkg::SENS_W-1:0]          sensor_left_outer_i,
  input  logic [lfpd_pkg::SENS_W-1:0]          sensor_left_inner_i,
  input  logic [lfpd_pkg::SENS_W-1:0]          sensor_middle_i,
  input  logic [lfpd_pkg::SENS_W-1:0]          sensor_right_inner_i,
  input  logic [lfpd_pkg::SENS_W-1:0]          sensor_right_outer_i,
  input  logic                                 consume_event_i,
  // output channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [lfpd_pkg::SPD_OUT_W-1:0] left_speed_o,
  output logic signed [lfpd_pkg::SPD_OUT_W-1:0] right_speed_o,
  output logic                                 at_crossing_o,
  output logic                                 crossing_pending_o,
  output logic [lfpd_pkg::CNT_W-1:0]           crossing_total_o,
  output logic                                 centered_o
);

  localparam int unsigned AccW = lfpd_pkg::ACC_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PD_START,
    S_PD_WAIT,
    S_FI_START,
    S_FI_WAIT,
    S_OUT
  } state_e;

  // Configuration registers
  logic [lfpd_pkg::GAIN_W-1:0] prop_gain_q, deriv_gain_q;
  logic [lfpd_pkg::WGT_W-1:0]  filt_wgt_q;
  logic [lfpd_pkg::SPD_W-1:0]  base_spd_q, steer_lim_q, speed_lim_q;
  logic [lfpd_pkg::THR_W-1:0]  cross_thr_q, center_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= lfpd_pkg::PROP_GAIN_RST;
      deriv_gain_q <= lfpd_pkg::DERIV_GAIN_RST;
      filt_wgt_q   <= lfpd_pkg::FILT_WGT_RST;
      base_spd_q   <= lfpd_pkg::BASE_SPD_RST;
      steer_lim_q  <= lfpd_pkg::STEER_LIM_RST;
      speed_lim_q  <= lfpd_pkg::SPEED_LIM_RST;
      cross_thr_q  <= lfpd_pkg::CROSS_THR_RST;
      center_thr_q <= lfpd_pkg::CENTER_THR_RST;
    end else if (cfg_we_i) begin
      case (lfpd_pkg::cfg_idx_e'(cfg_idx_i))
        lfpd_pkg::REG_PROP_GAIN:  prop_gain_q  <= cfg_data_i[lfpd_pkg::GAIN_W-1:0];
        lfpd_pkg::REG_DERIV_GAIN: deriv_gain_q <= cfg_data_i[lfpd_pkg::GAIN_W-1:0];
        lfpd_pkg::REG_FILT_WGT:   filt_wgt_q   <= cfg_data_i[lfpd_pkg::WGT_W-1:0];
        lfpd_pkg::REG_BASE_SPD:   base_spd_q   <= cfg_data_i[lfpd_pkg::SPD_W-1:0];
        lfpd_pkg::REG_STEER_LIM:  steer_lim_q  <= cfg_data_i[lfpd_pkg::SPD_W-1:0];
        lfpd_pkg::REG_SPEED_LIM:  speed_lim_q  <= cfg_data_i[lfpd_pkg::SPD_W-1:0];
        lfpd_pkg::REG_CROSS_THR:  cross_thr_q  <= cfg_data_i[lfpd_pkg::THR_W-1:0];
        lfpd_pkg::REG_CENTER_THR: center_thr_q <= cfg_data_i[lfpd_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // State and working registers
  state_e                                state_q;
  logic signed [lfpd_pkg::ERR_W-1:0]     err_q, prev_err_q;
  logic signed [lfpd_pkg::DERR_W-1:0]    derr_q;
  logic signed [lfpd_pkg::PD_W-1:0]      pd_q;
  logic signed [lfpd_pkg::STEER_W-1:0]   steer_q;
  logic                                  seen_last_q, pending_q;
  logic [lfpd_pkg::CNT_W-1:0]            counter_q;
  logic                                  at_q, pend_rep_q, centered_q;
  logic                                  out_valid_q;
  logic signed [lfpd_pkg::SPD_OUT_W-1:0] left_q, right_q;
  logic                                  at_out_q, pend_out_q, centered_out_q;
  logic [lfpd_pkg::CNT_W-1:0]            total_out_q;

  logic in_acc, out_acc;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;

  // Error from centre and its change
  logic [lfpd_pkg::POS_W-1:0]         pos_sat;
  logic signed [lfpd_pkg::ERR_W-1:0]  err_in;
  logic signed [lfpd_pkg::DERR_W-1:0] derr_in;

  assign pos_sat = (line_position_i > lfpd_pkg::MAX_POS) ? lfpd_pkg::MAX_POS : line_position_i;
  assign err_in  = $signed(pos_sat - lfpd_pkg::CENTRE_POS);
  assign derr_in = lfpd_pkg::DERR_W'(err_in) - lfpd_pkg::DERR_W'(prev_err_q);

  // Crossing and centred detection
  logic [4:0] over;
  logic [2:0] n_over;
  logic       at_in, rise_in, pend_new, centered_in;

  assign over[0] = sensor_left_outer_i  > cross_thr_q;
  assign over[1] = sensor_left_inner_i  > cross_thr_q;
  assign over[2] = sensor_middle_i      > cross_thr_q;
  assign over[3] = sensor_right_inner_i > cross_thr_q;
  assign over[4] = sensor_right_outer_i > cross_thr_q;
  assign n_over  = 3'(over[0]) + 3'(over[1]) + 3'(over[2]) + 3'(over[3]) + 3'(over[4]);
  assign at_in   = (n_over >= lfpd_pkg::MIN_ACTIVE) || (over[0] && over[4]);
  assign rise_in = at_in && !seen_last_q;
  assign pend_new = pending_q || rise_in;
  assign centered_in = (sensor_middle_i > center_thr_q) && !over[0] && !over[4] && !at_in;

  // Shared multiply-accumulate unit
  lfpd_pkg::mac_req_t mac_req;
  lfpd_pkg::mac_sts_t mac_sts;
  logic [lfpd_pkg::WGT_W-1:0] w_eff, v_eff;

  assign w_eff = (filt_wgt_q > lfpd_pkg::ONE_Q12) ? lfpd_pkg::ONE_Q12 : filt_wgt_q;
  assign v_eff = lfpd_pkg::ONE_Q12 - w_eff;

  always_comb begin
    mac_req.load = (state_q == S_PD_START) || (state_q == S_FI_START);
    if (state_q == S_FI_START) begin
      mac_req.opd_a = lfpd_pkg::OPD_W'(pd_q);
      mac_req.opd_b = lfpd_pkg::OPD_W'(steer_q);
      mac_req.mul_a = lfpd_pkg::MUL_W'(w_eff);
      mac_req.mul_b = lfpd_pkg::MUL_W'(v_eff);
    end else begin
      mac_req.opd_a = lfpd_pkg::OPD_W'(err_q);
      mac_req.opd_b = lfpd_pkg::OPD_W'(derr_q);
      mac_req.mul_a = lfpd_pkg::MUL_W'(prop_gain_q);
      mac_req.mul_b = lfpd_pkg::MUL_W'(deriv_gain_q);
    end
  end

  lfpd_mac #(
    .DigitW(DigitW)
  ) u_mac (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mac_req),
    .sts_o (mac_sts)
  );

  // PD term: scale down and saturate to 16 bits
  logic signed [AccW-1:0]              acc_q12;
  logic signed [AccW-1:0]              pd_sat;
  logic signed [AccW-1:0]              steer_lim_s;
  logic signed [AccW-1:0]              steer_clamp;

  assign acc_q12 = lfpd_pkg::q12_trunc(mac_sts.acc);
  assign pd_sat  = (acc_q12 > lfpd_pkg::PD_MAX) ? lfpd_pkg::PD_MAX :
                   (acc_q12 < lfpd_pkg::PD_MIN) ? lfpd_pkg::PD_MIN : acc_q12;

  // Filtered term clamped to the steering limit
  assign steer_lim_s = $signed(AccW'(steer_lim_q));
  assign steer_clamp = (acc_q12 > steer_lim_s)  ? steer_lim_s :
                       (acc_q12 < -steer_lim_s) ? -steer_lim_s : acc_q12;

  // Wheel speeds
  logic signed [lfpd_pkg::SUM_W-1:0] base_s, spd_lim_s, sum_l, sum_r, left_c, right_c;

  assign base_s    = $signed(lfpd_pkg::SUM_W'(base_spd_q));
  assign spd_lim_s = $signed(lfpd_pkg::SUM_W'(speed_lim_q));
  assign sum_l     = base_s + lfpd_pkg::SUM_W'(steer_q);
  assign sum_r     = base_s - lfpd_pkg::SUM_W'(steer_q);
  assign left_c    = (sum_l > spd_lim_s)  ? spd_lim_s :
                     (sum_l < -spd_lim_s) ? -spd_lim_s : sum_l;
  assign right_c   = (sum_r > spd_lim_s)  ? spd_lim_s :
                     (sum_r < -spd_lim_s) ? -spd_lim_s : sum_r;

  // Sequencer, filter and crossing state, output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      err_q          <= '0;
      prev_err_q     <= '0;
      derr_q         <= '0;
      pd_q           <= '0;
      steer_q        <= '0;
      seen_last_q    <= 1'b0;
      pending_q      <= 1'b0;
      counter_q      <= '0;
      at_q           <= 1'b0;
      pend_rep_q     <= 1'b0;
      centered_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      left_q         <= '0;
      right_q        <= '0;
      at_out_q       <= 1'b0;
      pend_out_q     <= 1'b0;
      centered_out_q <= 1'b0;
      total_out_q    <= '0;
    end else begin
      // result taken; in S_OUT a taken result is replaced in the same cycle
      if (out_acc && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            err_q       <= err_in;
            derr_q      <= derr_in;
            prev_err_q  <= err_in;
            seen_last_q <= at_in;
            counter_q   <= counter_q + lfpd_pkg::CNT_W'(rise_in);
            pending_q   <= pend_new && !consume_event_i;
            at_q        <= at_in;
            pend_rep_q  <= pend_new;
            centered_q  <= centered_in;
            state_q     <= S_PD_START;
          end
        end
        S_PD_START: begin
          state_q <= S_PD_WAIT;
        end
        S_PD_WAIT: begin
          if (!mac_sts.busy) begin
            pd_q    <= lfpd_pkg::PD_W'(pd_sat);
            state_q <= S_FI_START;
          end
        end
        S_FI_START: begin
          state_q <= S_FI_WAIT;
        end
        S_FI_WAIT: begin
          if (!mac_sts.busy) begin
            steer_q <= lfpd_pkg::STEER_W'(steer_clamp);
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q    <= 1'b1;
            left_q         <= lfpd_pkg::SPD_OUT_W'(left_c);
            right_q        <= lfpd_pkg::SPD_OUT_W'(right_c);
            at_out_q       <= at_q;
            pend_out_q     <= pend_rep_q;
            centered_out_q <= centered_q;
            total_out_q    <= counter_q;
            state_q        <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign left_speed_o       = left_q;
  assign right_speed_o      = right_q;
  assign at_crossing_o      = at_out_q;
  assign crossing_pending_o = pend_out_q;
  assign crossing_total_o   = total_out_q;
  assign centered_o         = centered_out_q;

endmodule

>>> rtl/lfpd_mac.sv
// Digit-serial two-lane multiply-accumulate: acc = opd_a*mul_a + opd_b*mul_b.
// Depends on lfpd_pkg; consumes the multipliers MSB digit first.

module lfpd_mac #(
  parameter int unsigned DigitW = lfpd_pkg::DIGIT_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lfpd_pkg::mac_req_t  req_i,
  output lfpd_pkg::mac_sts_t  sts_o
);

  localparam int unsigned NumDigits = (lfpd_pkg::MUL_W + DigitW - 1) / DigitW;
  localparam int unsigned ShW       = NumDigits * DigitW;
  localparam int unsigned CntW      = $clog2(NumDigits + 1);
  localparam int unsigned PpW       = lfpd_pkg::OPD_W + DigitW + 1;
  localparam int unsigned AccW      = lfpd_pkg::ACC_W;

  logic signed [lfpd_pkg::OPD_W-1:0] opd_a_q, opd_b_q;
  logic [ShW-1:0]                    sh_a_q, sh_b_q;
  logic signed [AccW-1:0]            acc_q, acc_d;
  logic [CntW-1:0]                   cnt_q;
  logic [DigitW-1:0]                 dig_a, dig_b;
  logic signed [PpW-1:0]             pp_a, pp_b;

  // Top digit of each multiplier shift register
  assign dig_a = sh_a_q[ShW-1 -: DigitW];
  assign dig_b = sh_b_q[ShW-1 -: DigitW];

  // Narrow partial products, one digit each
  assign pp_a = PpW'(opd_a_q) * PpW'($signed({1'b0, dig_a}));
  assign pp_b = PpW'(opd_b_q) * PpW'($signed({1'b0, dig_b}));

  // Horner step: shift previous sum up one digit and add
  assign acc_d = (acc_q <<< DigitW) + AccW'(pp_a) + AccW'(pp_b);

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (req_i.load) begin
      cnt_q <= CntW'(NumDigits);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  // Operands, shift registers and accumulator
  always_ff @(posedge clk_i) begin
    if (req_i.load) begin
      opd_a_q <= req_i.opd_a;
      opd_b_q <= req_i.opd_b;
      sh_a_q  <= ShW'(req_i.mul_a);
      sh_b_q  <= ShW'(req_i.mul_b);
      acc_q   <= '0;
    end else if (cnt_q != '0) begin
      sh_a_q <= sh_a_q << DigitW;
      sh_b_q <= sh_b_q << DigitW;
      acc_q  <= acc_d;
    end
  end

  assign sts_o.busy = (cnt_q != '0);
  assign sts_o.acc  = acc_q;

endmodule

>>> rtl/lfpd_checker.sv
// Port-level checks for the line follower PD block, bound to the top level.
// Depends on lfpd_pkg for port widths.

module lfpd_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_stall_o,
  input logic                                  out_valid_o,
  input logic                                  out_stall_i,
  input logic signed [lfpd_pkg::SPD_OUT_W-1:0] left_speed_o,
  input logic signed [lfpd_pkg::SPD_OUT_W-1:0] right_speed_o,
  input logic                                  at_crossing_o,
  input logic                                  crossing_pending_o,
  input logic [lfpd_pkg::CNT_W-1:0]            crossing_total_o,
  input logic                                  centered_o
);

  // One request at a time: after taking one the input side stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while previous request still in work");

  // Centred and crossing are exclusive in any result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(centered_o && at_crossing_o))
    else $error("result reports centred and crossing together");

  // The reported count only moves by one, on a new crossing that sets the pending flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $changed(crossing_total_o) |->
      (crossing_total_o == ($past(crossing_total_o) + lfpd_pkg::CNT_W'(1)))
      && crossing_pending_o && at_crossing_o)
    else $error("crossing count changed without a counted crossing");

  // Stalled result stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Stalled result payload holds: speeds, count and pending flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(left_speed_o) && $stable(right_speed_o)
      && $stable(crossing_total_o) && $stable(crossing_pending_o))
    else $error("result payload changed while stalled");

endmodule

bind line_follow_pd_with_crossing_detect lfpd_checker u_lfpd_checker (.*);

>>> test/tb_top.sv
`timescale 1ns / 100ps
// Testbench for line_follow_pd_with_crossing_detect: directed and random readings under
// several register settings and back-to-back crossing edges, checked by a predictor.
// Depends on lfpd_pkg and the block's RTL.

module tb_top;

  // one reading; lvl[0] is the left outer sensor, lvl[4] the right outer one
  typedef struct packed {
    logic [lfpd_pkg::POS_W-1:0]       pos;
    logic [4:0][lfpd_pkg::SENS_W-1:0] lvl;
    logic                             consume;
  } reading_t;

  // wheel drive and crossing status for one reading
  typedef struct packed {
    logic signed [lfpd_pkg::SPD_OUT_W-1:0] left;
    logic signed [lfpd_pkg::SPD_OUT_W-1:0] right;
    logic                                  at;
    logic                                  pend;
    logic [lfpd_pkg::CNT_W-1:0]            total;
    logic                                  centered;
  } drive_t;

  localparam int SENSOR_MAX = (1 << lfpd_pkg::SENS_W) - 1;

  logic                                  clk_i = 1'b0;
  logic                                  rst_ni = 1'b0;
  logic                                  cfg_we_i = 1'b0;
  logic [lfpd_pkg::CFG_IDX_W-1:0]        cfg_idx_i = '0;
  logic [lfpd_pkg::CFG_DAT_W-1:0]        cfg_data_i = '0;
  logic                                  in_valid_i = 1'b0;
  logic                                  in_stall_o;
  logic [lfpd_pkg::POS_W-1:0]            line_position_i = '0;
  logic [lfpd_pkg::SENS_W-1:0]           sensor_left_outer_i = '0;
  logic [lfpd_pkg::SENS_W-1:0]           sensor_left_inner_i = '0;
  logic [lfpd_pkg::SENS_W-1:0]           sensor_middle_i = '0;
  logic [lfpd_pkg::SENS_W-1:0]           sensor_right_inner_i = '0;
  logic [lfpd_pkg::SENS_W-1:0]           sensor_right_outer_i = '0;
  logic                                  consume_event_i = 1'b0;
  logic                                  out_valid_o;
  logic                                  out_stall_i = 1'b0;
  logic signed [lfpd_pkg::SPD_OUT_W-1:0] left_speed_o;
  logic signed [lfpd_pkg::SPD_OUT_W-1:0] right_speed_o;
  logic                                  at_crossing_o;
  logic                                  crossing_pending_o;
  logic [lfpd_pkg::CNT_W-1:0]            crossing_total_o;
  logic                                  centered_o;

  line_follow_pd_with_crossing_detect i_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .line_position_i      (line_position_i),
    .sensor_left_outer_i  (sensor_left_outer_i),
    .sensor_left_inner_i  (sensor_left_inner_i),
    .sensor_middle_i      (sensor_middle_i),
    .sensor_right_inner_i (sensor_right_inner_i),
    .sensor_right_outer_i (sensor_right_outer_i),
    .consume_event_i      (consume_event_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .left_speed_o         (left_speed_o),
    .right_speed_o        (right_speed_o),
    .at_crossing_o        (at_crossing_o),
    .crossing_pending_o   (crossing_pending_o),
    .crossing_total_o     (crossing_total_o),
    .centered_o           (centered_o)
  );

  // register copies, as the block should hold them
  logic [lfpd_pkg::GAIN_W-1:0] k_prop     = lfpd_pkg::PROP_GAIN_RST;
  logic [lfpd_pkg::GAIN_W-1:0] k_deriv    = lfpd_pkg::DERIV_GAIN_RST;
  logic [lfpd_pkg::WGT_W-1:0]  lp_weight  = lfpd_pkg::FILT_WGT_RST;
  logic [lfpd_pkg::SPD_W-1:0]  speed_base = lfpd_pkg::BASE_SPD_RST;
  logic [lfpd_pkg::SPD_W-1:0]  lim_steer  = lfpd_pkg::STEER_LIM_RST;
  logic [lfpd_pkg::SPD_W-1:0]  lim_speed  = lfpd_pkg::SPEED_LIM_RST;
  logic [lfpd_pkg::THR_W-1:0]  thr_cross  = lfpd_pkg::CROSS_THR_RST;
  logic [lfpd_pkg::THR_W-1:0]  thr_center = lfpd_pkg::CENTER_THR_RST;

  // filter and crossing state
  longint                      last_err   = 0;
  longint                      last_steer = 0;
  bit                          cross_prev = 1'b0;
  bit                          cross_flag = 1'b0;
  logic [lfpd_pkg::CNT_W-1:0]  cross_count = '0;

  drive_t            drive_q[$];
  int                mismatch_count = 0;
  int                result_count = 0;
  int                burst_left = 0;
  int                track_pos = 2000;
  bit                fast_mode = 1'b0;

  initial forever #5 clk_i = ~clk_i;

  // divide by 4096, truncating toward zero
  function automatic longint q12_toward_zero(input longint v);
    return (v < 0) ? -((-v) >>> lfpd_pkg::FRAC_W) : (v >>> lfpd_pkg::FRAC_W);
  endfunction

  function automatic longint clamp_sym(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // expected drive for one accepted reading; advances the state
  function automatic drive_t predict_drive(input reading_t r);
    drive_t      d;
    int unsigned hits;
    bit          out_l, out_r, at;
    longint      err, pd, filt, steer, w;
    hits = 0;
    for (int i = 0; i < 5; i++)
      if (r.lvl[i] > thr_cross) hits++;
    out_l = r.lvl[0] > thr_cross;
    out_r = r.lvl[4] > thr_cross;
    at = (hits >= lfpd_pkg::MIN_ACTIVE) || (out_l && out_r);
    if (at && !cross_prev) begin
      cross_count++;
      cross_flag = 1'b1;
    end
    cross_prev = at;

    // position saturates at the right end
    err = (r.pos > lfpd_pkg::MAX_POS) ? longint'(lfpd_pkg::MAX_POS) : longint'(r.pos);
    err -= longint'(lfpd_pkg::CENTRE_POS);
    pd = q12_toward_zero(longint'(k_prop) * err + longint'(k_deriv) * (err - last_err));
    if (pd > 32767) pd = 32767;
    if (pd < -32768) pd = -32768;
    // weight above one acts as one
    w = (lp_weight > lfpd_pkg::ONE_Q12) ? longint'(lfpd_pkg::ONE_Q12) : longint'(lp_weight);
    filt = q12_toward_zero(w * pd + (longint'(lfpd_pkg::ONE_Q12) - w) * last_steer);
    steer = clamp_sym(filt, longint'(lim_steer));
    last_err = err;
    last_steer = steer;

    d.left = lfpd_pkg::SPD_OUT_W'(clamp_sym(longint'(speed_base) + steer,
                                            longint'(lim_speed)));
    d.right = lfpd_pkg::SPD_OUT_W'(clamp_sym(longint'(speed_base) - steer,
                                             longint'(lim_speed)));
    d.at = at;
    d.pend = cross_flag;
    d.total = cross_count;
    d.centered = (r.lvl[2] > thr_center) && !out_l && !out_r && !at;
    if (r.consume) cross_flag = 1'b0;
    return d;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("ERROR %0t: %s", $time, msg);
  endtask

  // result checker
  task automatic check_drive();
    drive_t got, want;
    got = {left_speed_o, right_speed_o, at_crossing_o, crossing_pending_o,
           crossing_total_o, centered_o};
    result_count++;
    if (drive_q.size() == 0) begin
      report_mismatch($sformatf("result %0d arrived with none expected", result_count));
    end else begin
      want = drive_q.pop_front();
      if (got !== want)
        report_mismatch($sformatf({"result %0d got/exp: left %0d/%0d right %0d/%0d ",
          "at %b/%b pend %b/%b total %0d/%0d centered %b/%b"}, result_count,
          got.left, want.left, got.right, want.right, got.at, want.at, got.pend,
          want.pend, got.total, want.total, got.centered, want.centered));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_drive();
  end

  // receiver stall: stretches of no stall, light, heavy and alternating stall
  initial begin
    int unsigned span, mode;
    forever begin
      span = $urandom_range(1, 40);
      mode = $urandom_range(0, 3);
      repeat (span) begin
        @(negedge clk_i);
        if (fast_mode || mode == 0) out_stall_i <= 1'b0;
        else if (mode == 1) out_stall_i <= ($urandom_range(0, 3) == 0);
        else if (mode == 2) out_stall_i <= ($urandom_range(0, 3) != 0);
        else out_stall_i <= ~out_stall_i;
      end
    end
  end

  // register write; starts and ends at a falling edge
  task automatic write_reg(input lfpd_pkg::cfg_idx_e idx,
                           input logic [lfpd_pkg::CFG_DAT_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      lfpd_pkg::REG_PROP_GAIN:  k_prop = val[lfpd_pkg::GAIN_W-1:0];
      lfpd_pkg::REG_DERIV_GAIN: k_deriv = val[lfpd_pkg::GAIN_W-1:0];
      lfpd_pkg::REG_FILT_WGT:   lp_weight = val[lfpd_pkg::WGT_W-1:0];
      lfpd_pkg::REG_BASE_SPD:   speed_base = val[lfpd_pkg::SPD_W-1:0];
      lfpd_pkg::REG_STEER_LIM:  lim_steer = val[lfpd_pkg::SPD_W-1:0];
      lfpd_pkg::REG_SPEED_LIM:  lim_speed = val[lfpd_pkg::SPD_W-1:0];
      lfpd_pkg::REG_CROSS_THR:  thr_cross = val[lfpd_pkg::THR_W-1:0];
      lfpd_pkg::REG_CENTER_THR: thr_center = val[lfpd_pkg::THR_W-1:0];
      default: ;
    endcase
  endtask

  // extremes, default or random value; junk above the register width
  task automatic write_random_reg(input lfpd_pkg::cfg_idx_e idx, input int unsigned width,
                                  input int unsigned cap, input int unsigned dflt);
    int unsigned top, v;
    top = (1 << width) - 1;
    case ($urandom_range(0, 6))
      0:       v = 0;
      1:       v = top;
      2:       v = dflt;
      default: v = $urandom_range(0, cap);
    endcase
    write_reg(idx, lfpd_pkg::CFG_DAT_W'(($urandom & ~top) | v));
  endtask

  task automatic randomize_regs();
    write_random_reg(lfpd_pkg::REG_PROP_GAIN, lfpd_pkg::GAIN_W, 16384,
                     lfpd_pkg::PROP_GAIN_RST);
    write_random_reg(lfpd_pkg::REG_DERIV_GAIN, lfpd_pkg::GAIN_W, 16384,
                     lfpd_pkg::DERIV_GAIN_RST);
    write_random_reg(lfpd_pkg::REG_FILT_WGT, lfpd_pkg::WGT_W, 4096,
                     lfpd_pkg::FILT_WGT_RST);
    write_random_reg(lfpd_pkg::REG_BASE_SPD, lfpd_pkg::SPD_W, 511,
                     lfpd_pkg::BASE_SPD_RST);
    write_random_reg(lfpd_pkg::REG_STEER_LIM, lfpd_pkg::SPD_W, 511,
                     lfpd_pkg::STEER_LIM_RST);
    write_random_reg(lfpd_pkg::REG_SPEED_LIM, lfpd_pkg::SPD_W, 511,
                     lfpd_pkg::SPEED_LIM_RST);
    write_random_reg(lfpd_pkg::REG_CROSS_THR, lfpd_pkg::THR_W, 1023,
                     lfpd_pkg::CROSS_THR_RST);
    write_random_reg(lfpd_pkg::REG_CENTER_THR, lfpd_pkg::THR_W, 1023,
                     lfpd_pkg::CENTER_THR_RST);
  endtask

  // one request; called and returns at a falling edge; bursts with random gaps
  task automatic send_reading(input reading_t r);
    int unsigned gap;
    gap = 0;
    if (!fast_mode) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
      burst_left--;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    line_position_i <= r.pos;
    sensor_left_outer_i <= r.lvl[0];
    sensor_left_inner_i <= r.lvl[1];
    sensor_middle_i <= r.lvl[2];
    sensor_right_inner_i <= r.lvl[3];
    sensor_right_outer_i <= r.lvl[4];
    consume_event_i <= r.consume;
    do @(posedge clk_i); while (in_stall_o);
    drive_q.push_back(predict_drive(r));
    @(negedge clk_i);
  endtask

  // stop sending and wait for every expected drive
  task automatic drain();
    in_valid_i <= 1'b0;
    while (drive_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic reading_t make_reading(input int unsigned pos, lo, li, mid, ri, ro,
                                            input bit consume);
    reading_t r;
    r.pos = lfpd_pkg::POS_W'(pos);
    r.lvl[0] = lfpd_pkg::SENS_W'(lo);
    r.lvl[1] = lfpd_pkg::SENS_W'(li);
    r.lvl[2] = lfpd_pkg::SENS_W'(mid);
    r.lvl[3] = lfpd_pkg::SENS_W'(ri);
    r.lvl[4] = lfpd_pkg::SENS_W'(ro);
    r.consume = consume;
    return r;
  endfunction

  // level on or off the line for the current crossing threshold
  function automatic logic [lfpd_pkg::SENS_W-1:0] sensor_level(input bit on);
    if (!on) return lfpd_pkg::SENS_W'($urandom_range(0, int'(thr_cross)));
    if (int'(thr_cross) >= SENSOR_MAX) return lfpd_pkg::SENS_W'(SENSOR_MAX);
    return lfpd_pkg::SENS_W'($urandom_range(int'(thr_cross) + 1, SENSOR_MAX));
  endfunction

  // following the line: outer sensors off, position wanders
  function automatic reading_t track_reading();
    reading_t r;
    track_pos += int'($urandom_range(0, 600)) - 300;
    if (track_pos < 0) track_pos = 0;
    if (track_pos > 4000) track_pos = 4000;
    if ($urandom_range(0, 15) == 0) track_pos = int'($urandom_range(0, 4000));
    r.pos = lfpd_pkg::POS_W'(track_pos);
    r.lvl[0] = sensor_level(1'b0);
    r.lvl[1] = sensor_level(1'($urandom_range(0, 1)));
    r.lvl[2] = sensor_level($urandom_range(0, 3) != 0);
    r.lvl[3] = sensor_level(1'($urandom_range(0, 1)));
    r.lvl[4] = sensor_level(1'b0);
    r.consume = ($urandom_range(0, 3) == 0);
    return r;
  endfunction

  // on a crossing: four or five sensors on, or both outer ones
  function automatic reading_t cross_reading();
    reading_t    r;
    int unsigned skip;
    r = track_reading();
    skip = $urandom_range(0, 5);
    if ($urandom_range(0, 2) == 0) begin
      r.lvl[0] = sensor_level(1'b1);
      r.lvl[4] = sensor_level(1'b1);
    end else begin
      for (int i = 0; i < 5; i++) r.lvl[i] = sensor_level(i != skip);
    end
    return r;
  endfunction

  function automatic reading_t noise_reading();
    reading_t r;
    r.pos = lfpd_pkg::POS_W'($urandom_range(0, (1 << lfpd_pkg::POS_W) - 1));
    for (int i = 0; i < 5; i++) r.lvl[i] = lfpd_pkg::SENS_W'($urandom_range(0, SENSOR_MAX));
    r.consume = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // mostly line following and crossings, some noise
  task automatic random_readings(input int unsigned count);
    int unsigned sent, a, b, c;
    sent = 0;
    while (sent < count) begin
      a = $urandom_range(1, 3);
      b = $urandom_range(1, 4);
      c = $urandom_range(1, 3);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          a = $urandom_range(3, 10);
          repeat (a) send_reading(track_reading());
          sent += a;
        end
        5, 6, 7: begin
          repeat (a) send_reading(track_reading());
          repeat (b) send_reading(cross_reading());
          repeat (c) send_reading(track_reading());
          sent += a + b + c;
        end
        default: begin
          repeat (b) send_reading(noise_reading());
          sent += b;
        end
      endcase
    end
  endtask

  // reset values: field extremes, centering, both kinds of crossing, flag clear
  task automatic test_default_regs();
    send_reading(make_reading(2000, 0, 0, 1000, 0, 0, 1'b0));
    send_reading(make_reading(0, 0, 0, 0, 0, 0, 1'b0));
    send_reading(make_reading(4000, 0, 0, 0, 0, 0, 1'b0));
    send_reading(make_reading(4095, 1023, 0, 0, 0, 0, 1'b0));
    send_reading(make_reading(4001, 0, 0, 650, 0, 0, 1'b0));
    send_reading(make_reading(2000, 0, 0, 651, 0, 0, 1'b0));
    send_reading(make_reading(2000, 601, 0, 700, 0, 601, 1'b0));
    send_reading(make_reading(2000, 1023, 1023, 1023, 1023, 1023, 1'b1));
    send_reading(make_reading(2000, 0, 0, 700, 0, 0, 1'b0));
    send_reading(make_reading(1500, 0, 700, 700, 700, 700, 1'b0));
    send_reading(make_reading(2500, 0, 0, 0, 0, 0, 1'b1));
    send_reading(make_reading(2000, 600, 600, 600, 600, 600, 1'b0));
    send_reading(make_reading(2000, 1023, 1023, 1023, 1023, 1023, 1'b1));
    send_reading(make_reading(2000, 0, 0, 0, 0, 0, 1'b0));
  endtask

  // all registers at their top, at zero, then a unity filter weight
  task automatic test_register_extremes();
    drain();
    write_reg(lfpd_pkg::REG_PROP_GAIN, 16'hFFFF);
    write_reg(lfpd_pkg::REG_DERIV_GAIN, 16'hFFFF);
    write_reg(lfpd_pkg::REG_FILT_WGT, 16'hFFFF);
    write_reg(lfpd_pkg::REG_BASE_SPD, 16'hFFFF);
    write_reg(lfpd_pkg::REG_STEER_LIM, 16'hFFFF);
    write_reg(lfpd_pkg::REG_SPEED_LIM, 16'hFFFF);
    write_reg(lfpd_pkg::REG_CROSS_THR, 16'hFFFF);
    write_reg(lfpd_pkg::REG_CENTER_THR, 16'hFFFF);
    send_reading(make_reading(0, 1023, 1023, 1023, 1023, 1023, 1'b1));
    send_reading(make_reading(4000, 1023, 1023, 1023, 1023, 1023, 1'b1));
    send_reading(make_reading(0, 1023, 1023, 1023, 1023, 1023, 1'b0));
    send_reading(make_reading(4095, 1023, 1023, 1023, 1023, 1023, 1'b0));
    drain();
    write_reg(lfpd_pkg::REG_PROP_GAIN, 16'd0);
    write_reg(lfpd_pkg::REG_DERIV_GAIN, 16'd0);
    write_reg(lfpd_pkg::REG_FILT_WGT, 16'd0);
    write_reg(lfpd_pkg::REG_BASE_SPD, 16'd0);
    write_reg(lfpd_pkg::REG_STEER_LIM, 16'd0);
    write_reg(lfpd_pkg::REG_SPEED_LIM, 16'd0);
    write_reg(lfpd_pkg::REG_CROSS_THR, 16'd0);
    write_reg(lfpd_pkg::REG_CENTER_THR, 16'd0);
    send_reading(make_reading(0, 1, 0, 0, 0, 1, 1'b0));
    send_reading(make_reading(4000, 0, 0, 1, 0, 0, 1'b1));
    send_reading(make_reading(2000, 0, 0, 0, 0, 0, 1'b0));
    drain();
    write_reg(lfpd_pkg::REG_FILT_WGT, 16'd4096);
    write_reg(lfpd_pkg::REG_PROP_GAIN, 16'd4096);
    write_reg(lfpd_pkg::REG_STEER_LIM, 16'd511);
    write_reg(lfpd_pkg::REG_SPEED_LIM, 16'd511);
    send_reading(make_reading(3000, 0, 0, 0, 0, 0, 1'b0));
    send_reading(make_reading(1000, 0, 0, 0, 0, 0, 1'b0));
  endtask

  // random register settings, each followed by random readings
  task automatic test_random_settings();
    for (int p = 0; p < 6; p++) begin
      drain();
      randomize_regs();
      random_readings(100);
    end
  endtask

  // crossing edges back to back with no idle cycles and no receiver stall
  task automatic test_crossing_edges();
    drain();
    write_reg(lfpd_pkg::REG_CROSS_THR, lfpd_pkg::CROSS_THR_RST);
    fast_mode = 1'b1;
    repeat (10) begin
      send_reading(make_reading(2000, 0, 0, 1023, 0, 0, 1'($urandom_range(0, 1))));
      send_reading(make_reading(2000, 1023, 1023, 1023, 1023, 1023,
                                1'($urandom_range(0, 1))));
    end
    fast_mode = 1'b0;
    drain();
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_default_regs();
    test_register_extremes();
    test_random_settings();
    test_crossing_edges();
    repeat (12) @(negedge clk_i);
    if (mismatch_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
